/* sv/wae_pkg.sv */
// Package for the window alarm evaluator: table sizes, field widths,
// function codes and the condition slot type. No dependencies.
`timescale 1ns / 1ps

package wae_pkg;

    // Table sizes
    localparam int NUM_ALARMS       = 4;
    localparam int SLOTS_PER_ALARM  = 4;
    localparam int NUM_SENSOR_KINDS = 16;
    localparam int TOTAL_SLOTS      = NUM_ALARMS * SLOTS_PER_ALARM;

    // Index widths, never below one bit
    localparam int ALARM_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int POS_W   = (SLOTS_PER_ALARM > 1) ? $clog2(SLOTS_PER_ALARM) : 1;
    localparam int SLOT_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int KIND_W  = (NUM_SENSOR_KINDS > 1) ? $clog2(NUM_SENSOR_KINDS) : 1;

    // Fixed field widths
    localparam int FUNC_W   = 3;
    localparam int AIDX_W   = 2;
    localparam int SKIND_W  = 4;
    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int MASK_W   = 4;
    localparam int IN_DW    = 104;
    localparam int OUT_DW   = 8;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_VALUE   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READY   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DISABLE = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd6;

    // Window modes
    localparam logic [MODE_W-1:0] MODE_INSIDE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUTSIDE = 2'd2;

    // One condition slot; kind zero marks it unused
    typedef struct packed {
        logic [SKIND_W-1:0]        kind;
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] lower;
        logic signed [VALUE_W-1:0] upper;
    } slot_t;

endpackage

/* sv/wae_window_cmp.sv */
// Shared window compare unit: tests one reading against one slot window.
// Depends on wae_pkg for the slot type.
`timescale 1ns / 1ps

module wae_window_cmp (
    input  wae_pkg::slot_t              slot,
    input  logic signed [31:0]          reading,
    output logic                        holds
);
    import wae_pkg::*;

    logic lower_ok;
    logic upper_ok;

    // Signed, inclusive limit compares
    assign lower_ok = (slot.lower <= reading);
    assign upper_ok = (reading <= slot.upper);

    // Select by window mode; disabled and unknown modes fail
    always_comb
    begin
        case (slot.mode)
            MODE_INSIDE:  holds = lower_ok && upper_ok;
            MODE_OUTSIDE: holds = !lower_ok || !upper_ok;
            default:      holds = 1'b0;
        endcase
    end

endmodule

/* sv/window_alarm_evaluator_core.sv */
// Top level of the window alarm evaluator: sequencer, alarm and slot tables,
// stream ports. Depends on wae_pkg and wae_window_cmp.
`timescale 1ns / 1ps

// One input word yields one output word. A tick with data pending walks all
// TOTAL_SLOTS condition slots through the single window compare unit, one
// slot per cycle, then updates every alarm count together in the sound step
// and offers the result word from the finish step once the output register
// is free. A tick without data pending skips the slot walk.
// A set condition scans the alarm's slots one per cycle up to the first free
// or matching one, a delete clears them one per cycle, and every other
// function goes straight to the finish step.
// s_tready is high only between items; a result word waiting on m_tready
// does not stop the next item from being taken and worked on.
module window_alarm_evaluator_core (
    input  logic        clk,
    input  logic        rst_n,
    // fields from bit 0: alarm_index[1:0], sensor_kind[5:2],
    // sensor_value[37:6], interval_mode[39:38], lower_bound[71:40],
    // upper_bound[103:72]
    input  logic [103:0] s_tdata,
    // fields from bit 0: func[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: beep_mask[3:0], set_accepted[4],
    // data_pending_out[5], zero fill [7:6]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);
    import wae_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_SOUND  = 3'd2;
    localparam logic [2:0] ST_SET    = 3'd3;
    localparam logic [2:0] ST_DELETE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Input fields
    logic [AIDX_W-1:0]         in_alarm;
    logic [SKIND_W-1:0]        in_kind;
    logic [VALUE_W-1:0]        in_value;
    logic [MODE_W-1:0]         in_mode;
    logic [VALUE_W-1:0]        in_lower;
    logic [VALUE_W-1:0]        in_upper;
    logic                      in_alarm_ok;
    logic                      in_kind_ok;
    logic [ALARM_W-1:0]        in_alarm_idx;

    // Control and tables
    logic [2:0]                state_reg, state_next;
    logic [SKIND_W-1:0]        kind_reg, kind_next;
    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic [VALUE_W-1:0]        lower_reg, lower_next;
    logic [VALUE_W-1:0]        upper_reg, upper_next;
    logic [VALUE_W-1:0]        readings_reg [NUM_SENSOR_KINDS];
    logic [VALUE_W-1:0]        readings_next [NUM_SENSOR_KINDS];
    slot_t                     slots_reg [TOTAL_SLOTS];
    slot_t                     slots_next [TOTAL_SLOTS];
    logic [NUM_ALARMS-1:0]     enable_reg, enable_next;
    logic [COUNT_W-1:0]        count_reg [NUM_ALARMS];
    logic [COUNT_W-1:0]        count_next [NUM_ALARMS];
    logic [NUM_ALARMS-1:0]     hold_reg, hold_next;
    logic                      pending_reg, pending_next;
    logic [COUNT_W-1:0]        beep_reg, beep_next;
    logic [SLOT_W-1:0]         slot_idx_reg, slot_idx_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [ALARM_W-1:0]        alarm_cnt_reg, alarm_cnt_next;
    logic                      acc_reg, acc_next;
    logic [MASK_W-1:0]         mask_reg, mask_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_DW-1:0]         out_data_reg, out_data_next;

    // Shared compare unit operands
    slot_t                     cur_slot;
    logic signed [VALUE_W-1:0] cur_reading;
    logic                      cur_holds;
    logic                      last_pos;

    // Unpack the input word
    assign in_alarm     = s_tdata[1:0];
    assign in_kind      = s_tdata[5:2];
    assign in_value     = s_tdata[37:6];
    assign in_mode      = s_tdata[39:38];
    assign in_lower     = s_tdata[71:40];
    assign in_upper     = s_tdata[103:72];
    assign in_alarm_ok  = (32'(in_alarm) < NUM_ALARMS);
    assign in_kind_ok   = (32'(in_kind) < NUM_SENSOR_KINDS);
    assign in_alarm_idx = ALARM_W'(in_alarm);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Fetch the slot under the sequencer and its sensor reading
    assign cur_slot    = slots_reg[slot_idx_reg];
    assign cur_reading = (32'(cur_slot.kind) < NUM_SENSOR_KINDS)
                         ? readings_reg[KIND_W'(cur_slot.kind)] : '0;
    assign last_pos    = (pos_reg == POS_W'(SLOTS_PER_ALARM - 1));

    wae_window_cmp u_cmp (
        .slot    (cur_slot),
        .reading (cur_reading),
        .holds   (cur_holds)
    );

    // Sequencer and table updates
    always_comb
    begin
        logic [COUNT_W-1:0]    base;
        logic [NUM_ALARMS-1:0] snd;

        state_next     = state_reg;
        kind_next      = kind_reg;
        mode_next      = mode_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        readings_next  = readings_reg;
        slots_next     = slots_reg;
        enable_next    = enable_reg;
        count_next     = count_reg;
        hold_next      = hold_reg;
        pending_next   = pending_reg;
        beep_next      = beep_reg;
        slot_idx_next  = slot_idx_reg;
        pos_next       = pos_reg;
        alarm_cnt_next = alarm_cnt_reg;
        acc_next       = acc_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        snd            = '0;
        base           = '0;

        // Drop the output word once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Take a configuration write
        if (cfg_valid)
        begin
            beep_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next     = in_kind;
                    mode_next     = in_mode;
                    lower_next    = in_lower;
                    upper_next    = in_upper;
                    acc_next      = 1'b0;
                    mask_next     = '0;
                    pos_next      = '0;
                    slot_idx_next = SLOT_W'(32'(in_alarm_idx) * SLOTS_PER_ALARM);
                    state_next    = ST_FINISH;
                    case (s_tuser)
                        FUNC_VALUE:
                        begin
                            if (in_kind_ok)
                            begin
                                readings_next[KIND_W'(in_kind)] = in_value;
                            end
                        end
                        FUNC_READY:
                        begin
                            pending_next = 1'b1;
                        end
                        FUNC_TICK:
                        begin
                            slot_idx_next  = '0;
                            alarm_cnt_next = '0;
                            hold_next      = '1;
                            state_next     = pending_reg ? ST_EVAL : ST_SOUND;
                        end
                        FUNC_SET:
                        begin
                            if (in_alarm_ok && in_kind_ok)
                            begin
                                state_next = ST_SET;
                            end
                        end
                        FUNC_ENABLE:
                        begin
                            if (in_alarm_ok)
                            begin
                                enable_next[in_alarm_idx] = 1'b1;
                            end
                        end
                        FUNC_DISABLE:
                        begin
                            if (in_alarm_ok)
                            begin
                                enable_next[in_alarm_idx] = 1'b0;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (in_alarm_ok)
                            begin
                                enable_next[in_alarm_idx] = 1'b0;
                                count_next[in_alarm_idx]  = '0;
                                state_next                = ST_DELETE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Test one slot per cycle, clear the hold of its alarm on a miss
            ST_EVAL:
            begin
                if (cur_slot.kind != '0 && !cur_holds)
                begin
                    hold_next[alarm_cnt_reg] = 1'b0;
                end
                if (slot_idx_reg == SLOT_W'(TOTAL_SLOTS - 1))
                begin
                    state_next = ST_SOUND;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + 1'b1;
                    if (last_pos)
                    begin
                        pos_next       = '0;
                        alarm_cnt_next = alarm_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            // Load counts when data is pending, sound and decrement every enabled alarm whose count is nonzero
            ST_SOUND:
            begin
                for (int a = 0; a < NUM_ALARMS; a++)
                begin
                    base = count_reg[a];
                    if (pending_reg && enable_reg[a])
                    begin
                        base = hold_reg[a] ? beep_reg : '0;
                    end
                    if (enable_reg[a] && base != '0)
                    begin
                        snd[a]        = 1'b1;
                        count_next[a] = base - 1'b1;
                    end
                    else
                    begin
                        count_next[a] = base;
                    end
                end
                pending_next = |snd;
                mask_next    = MASK_W'(snd);
                state_next   = ST_FINISH;
            end

            // Scan the alarm's slots for a free or matching one
            ST_SET:
            begin
                if (cur_slot.kind == '0 || cur_slot.kind == kind_reg)
                begin
                    slots_next[slot_idx_reg] = '{kind:  kind_reg, mode: mode_reg,
                                                 lower: lower_reg, upper: upper_reg};
                    acc_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (last_pos)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + 1'b1;
                    pos_next      = pos_reg + 1'b1;
                end
            end

            // Clear the alarm's slots one per cycle
            ST_DELETE:
            begin
                slots_next[slot_idx_reg] = '0;
                if (last_pos)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + 1'b1;
                    pos_next      = pos_reg + 1'b1;
                end
            end

            // Hand the result to the output register when it is free
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, pending_reg, acc_reg, mask_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            readings_reg  <= '{default: '0};
            slots_reg     <= '{default: '0};
            enable_reg    <= '0;
            count_reg     <= '{default: '0};
            pending_reg   <= 1'b0;
            beep_reg      <= COUNT_W'(3);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            readings_reg  <= readings_next;
            slots_reg     <= slots_next;
            enable_reg    <= enable_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            beep_reg      <= beep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and sequencer payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        mode_reg      <= mode_next;
        lower_reg     <= lower_next;
        upper_reg     <= upper_next;
        hold_reg      <= hold_next;
        slot_idx_reg  <= slot_idx_next;
        pos_reg       <= pos_next;
        alarm_cnt_reg <= alarm_cnt_next;
        acc_reg       <= acc_next;
        mask_reg      <= mask_next;
        out_data_reg  <= out_data_next;
    end

    // A new output word only comes from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("output word loaded outside finish step");

    // Any alarm that sounds leaves data pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[3:0] != '0) |-> out_data_reg[5])
        else $error("alarm sounded without data pending");

    // An accepted set never reports sounding alarms
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[4]) |-> out_data_reg[3:0] == '0)
        else $error("set acceptance and beep mask both set");

    // A stalled output word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("output word changed while stalled");

endmodule
